FILE: src/mtf_pkg.sv
// shared types and constants for the max tracking fifo
package mtf_pkg;

  localparam int CMD_W   = 2;
  localparam int VALUE_W = 16;
  localparam int COUNT_W = 5;
  localparam int ERR_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_STATUS = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } dp_sts_t;

endpackage

FILE: src/mtf_in_if.sv
// request channel: command and value
interface mtf_in_if
  import mtf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

FILE: src/mtf_out_if.sv
// result channel: queue status after each operation
interface mtf_out_if
  import mtf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] front_value;
  logic [VALUE_W-1:0] max_value;
  logic [COUNT_W-1:0] count;
  logic               is_empty;
  logic [ERR_W-1:0]   error;

  modport source (output valid, output front_value, output max_value, output count,
                  output is_empty, output error, input ready);
  modport sink (input valid, input front_value, input max_value, input count,
                input is_empty, input error, output ready);
endinterface

FILE: src/mtf_ctrl.sv
// controller state machine: accept, rescan, result load
module mtf_ctrl
  import mtf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.need_scan ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the result slot to drain
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/mtf_dp.sv
// datapath: entry memory, pointers, running max and rescan
module mtf_dp
  import mtf_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [VALUE_W-1:0] in_value,
  output logic [VALUE_W-1:0] out_front_value,
  output logic [VALUE_W-1:0] out_max_value,
  output logic [COUNT_W-1:0] out_count,
  output logic               out_is_empty,
  output logic [ERR_W-1:0]   out_error
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]    head_r, scan_ptr_r;
  logic [CW-1:0]    cnt_r, scan_left_r;
  logic [WIDTH-1:0] max_r, front_r, best_r, rd_data_r;
  logic             rd_vld_r, rd_first_r, rescan_r;
  err_t             err_r;

  logic [VALUE_W-1:0] front_o_r, max_o_r;
  logic [COUNT_W-1:0] count_o_r;
  logic               empty_o_r;
  err_t               err_o_r;

  cmd_t             op;
  logic             full, empty, push_ok, pop_ok;
  logic [WIDTH-1:0] val_w, best_nxt;
  logic [SW-1:0]    tail_sum;
  logic [AW-1:0]    tail, head_inc;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign op       = cmd_t'(in_command);
  assign val_w    = WIDTH'(in_value);
  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign push_ok  = (op == CMD_PUSH) && !full;
  assign pop_ok   = (op == CMD_POP) && !empty;
  assign head_inc = ptr_inc(head_r);
  assign tail_sum = SW'(head_r) + SW'(cnt_r);
  assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign best_nxt = (rd_data_r > best_r) ? rd_data_r : best_r;

  // a pop that leaves entries behind must fetch the new front
  assign sts.need_scan = pop_ok && (cnt_r > CW'(1));
  assign sts.scan_done = (scan_left_r == '0) && !rd_vld_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && push_ok) begin
      mem[tail] <= val_w;
    end
    rd_data_r <= mem[scan_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      cnt_r       <= '0;
      max_r       <= '0;
      scan_left_r <= '0;
      rd_vld_r    <= 1'b0;
    end else if (cmd.accept) begin
      rd_vld_r    <= 1'b0;
      scan_left_r <= '0;
      if (push_ok) begin
        cnt_r <= cnt_r + CW'(1);
        if (val_w > max_r) begin
          max_r <= val_w;
        end
      end else if (pop_ok) begin
        head_r      <= head_inc;
        cnt_r       <= cnt_r - CW'(1);
        scan_left_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          max_r <= '0;
        end
      end
    end else if (cmd.scan) begin
      rd_vld_r <= (scan_left_r != '0);
      if (scan_left_r != '0) begin
        scan_left_r <= scan_left_r - CW'(1);
      end
      if (sts.scan_done && rescan_r) begin
        max_r <= best_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_ptr_r <= head_inc;
      best_r     <= '0;
      rd_first_r <= 1'b1;
      rescan_r   <= (front_r == max_r);
      if (push_ok && empty) begin
        front_r <= val_w;
      end
      if (op == CMD_PUSH && full) begin
        err_r <= ERR_FULL;
      end else if (op == CMD_POP && empty) begin
        err_r <= ERR_EMPTY;
      end else begin
        err_r <= ERR_OK;
      end
    end else if (cmd.scan) begin
      if (scan_left_r != '0) begin
        scan_ptr_r <= ptr_inc(scan_ptr_r);
      end
      if (rd_vld_r) begin
        best_r     <= best_nxt;
        rd_first_r <= 1'b0;
        if (rd_first_r) begin
          front_r <= rd_data_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      front_o_r <= empty ? '0 : VALUE_W'(front_r);
      max_o_r   <= empty ? '0 : VALUE_W'(max_r);
      count_o_r <= COUNT_W'(cnt_r);
      empty_o_r <= empty;
      err_o_r   <= err_r;
    end
  end

  assign out_front_value = front_o_r;
  assign out_max_value   = max_o_r;
  assign out_count       = count_o_r;
  assign out_is_empty    = empty_o_r;
  assign out_error       = err_o_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("held count above depth");

  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && push_ok) |=> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("push did not advance count");

  a_empty_max: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (max_r == '0))
    else $error("empty queue holds nonzero max");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_left_r <= cnt_r)
    else $error("rescan runs past held entries");
`endif

endmodule

FILE: src/max_tracking_fifo.sv
// top level of the max tracking fifo
// push, status, rejected ops and a pop that empties go from IDLE to FINISH, which loads the result
// registers and raises out_valid; other pops first pass through SCAN, which rescans the entries left
// the rescan makes one memory read per cycle through the single read port; no new word is taken until IDLE
// a waiting result holds the next word at its result load
// synchronous active-low reset clears head pointer, count, max, rescan counter and control; memory not cleared
module max_tracking_fifo
  import mtf_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  mtf_in_if.sink    in_chan,
  mtf_out_if.source out_chan
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  mtf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  mtf_dp #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .sts             (dp_sts),
    .in_command      (in_chan.command),
    .in_value        (in_chan.value),
    .out_front_value (out_chan.front_value),
    .out_max_value   (out_chan.max_value),
    .out_count       (out_chan.count),
    .out_is_empty    (out_chan.is_empty),
    .out_error       (out_chan.error)
  );

endmodule

FILE: tb/fifo_status_checker.sv
// checker for the max tracking fifo: predicts each status word and compares it
`timescale 1ns / 1ps

module fifo_status_checker
  import mtf_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  mtf_in_if    in_chan,
  mtf_out_if   out_chan,
  output int   awaiting,
  output int   mismatches
);

  typedef struct packed {
    logic [VALUE_W-1:0] front_value;
    logic [VALUE_W-1:0] max_value;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    err_t               error;
  } status_word_t;

  // shadow copy of the queue contents
  logic [VALUE_W-1:0] slots [DEPTH];
  int                 head;
  int                 held;
  logic [VALUE_W-1:0] peak;

  status_word_t status_q [$];
  int           fail_tally;

  function automatic logic [VALUE_W-1:0] rescan_peak();
    logic [VALUE_W-1:0] best;
    best = '0;
    for (int i = 0; i < held; i++) begin
      if (slots[(head + i) % DEPTH] > best) best = slots[(head + i) % DEPTH];
    end
    return best;
  endfunction

  function automatic status_word_t apply_command(cmd_t cmd, logic [VALUE_W-1:0] val);
    status_word_t       res;
    logic [VALUE_W-1:0] gone;
    res.error = ERR_OK;
    case (cmd)
      CMD_PUSH: begin
        if (held >= DEPTH) begin
          res.error = ERR_FULL;
        end else begin
          slots[(head + held) % DEPTH] = val;
          held++;
          if (val > peak) peak = val;
        end
      end
      CMD_POP: begin
        if (held == 0) begin
          res.error = ERR_EMPTY;
        end else begin
          gone = slots[head];
          head = (head + 1) % DEPTH;
          held--;
          // removing the maximum forces a full rescan of what is left
          if (gone == peak) peak = rescan_peak();
        end
      end
      default: ;
    endcase
    res.count       = COUNT_W'(held);
    res.is_empty    = (held == 0);
    res.front_value = (held == 0) ? '0 : slots[head];
    res.max_value   = (held == 0) ? '0 : peak;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    status_word_t got;
    status_word_t want;
    if (!rst_n) begin
      head = 0;
      held = 0;
      peak = '0;
      status_q.delete();
    end else begin
      // results first, so a word arriving with nothing queued is never masked
      if (out_chan.valid && out_chan.ready) begin
        got.front_value = out_chan.front_value;
        got.max_value   = out_chan.max_value;
        got.count       = out_chan.count;
        got.is_empty    = out_chan.is_empty;
        got.error       = err_t'(out_chan.error);
        if (status_q.size() == 0) begin
          $error("result word with no command waiting");
          fail_tally++;
        end else begin
          want = status_q.pop_front();
          if (got.front_value !== want.front_value) begin
            $error("front_value: expected %0h, got %0h", want.front_value, got.front_value);
            fail_tally++;
          end
          if (got.max_value !== want.max_value) begin
            $error("max_value: expected %0h, got %0h", want.max_value, got.max_value);
            fail_tally++;
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            fail_tally++;
          end
          if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
            fail_tally++;
          end
          if (got.error !== want.error) begin
            $error("error: expected %0d, got %0d", want.error, got.error);
            fail_tally++;
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        status_q.push_back(apply_command(cmd_t'(in_chan.command), in_chan.value));
      end
    end
    awaiting   <= status_q.size();
    mismatches <= fail_tally;
  end

endmodule

FILE: tb/max_tracking_fifo_test.sv
// top of the max tracking fifo testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module max_tracking_fifo_test;
  import mtf_pkg::*;

  localparam int DEPTH = 16;
  localparam int WIDTH = 16;

  logic clk;
  logic rst_n;
  int   awaiting;
  int   mismatches;
  bit   quiet;

  mtf_in_if  in_chan ();
  mtf_out_if out_chan ();

  max_tracking_fifo #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  fifo_status_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .awaiting  (awaiting),
    .mismatches(mismatches)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // quiet stretches run both sides with no idle cycles
  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [VALUE_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return VALUE_W'($urandom_range(0, 7));  // repeats of the maximum
      5:       return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic cmd_t pick_command(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return CMD_PUSH;
    if (r < 94) return CMD_POP;
    if (r < 97) return CMD_STATUS;
    return CMD_RSVD;
  endfunction

  task automatic send_word(cmd_t cmd, logic [VALUE_W-1:0] val);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.command <= cmd;
    in_chan.value   <= val;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  // result side: random stalls before each word
  initial begin : sink_side
    int stall;
    out_chan.ready <= 1'b0;
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  initial begin : stimulus
    int phase_left;
    int push_pct;
    phase_left = 0;
    push_pct   = 50;
    quiet      = 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.command <= CMD_STATUS;
    in_chan.value   <= '0;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue corners, then fill past full and pop the maximum
    send_word(CMD_STATUS, 16'hFFFF);
    send_word(CMD_POP, 16'h0000);
    send_word(CMD_RSVD, 16'h5A5A);
    send_word(CMD_PUSH, 16'h0000);
    send_word(CMD_PUSH, 16'hFFFF);
    for (int i = 0; i < DEPTH - 2; i++) begin
      send_word(CMD_PUSH, (i == 7) ? 16'hFFFF : (16'h0001 << i));
    end
    send_word(CMD_PUSH, 16'h1234);
    send_word(CMD_POP, 16'hFFFF);
    send_word(CMD_POP, 16'h0000);
    send_word(CMD_STATUS, 16'h0000);
    drain();

    for (int n = 0; n < 1500; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 120);
        case ($urandom_range(0, 2))
          0:       push_pct = 75;
          1:       push_pct = 25;
          default: push_pct = 48;
        endcase
        quiet = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      if (n == 750) drain();
      send_word(pick_command(push_pct), draw_value());
    end

    drain();
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
